// ===== rtl/core/gps_pkg.sv =====
// ----------------------------------------------------------------------------
// gps_pkg
// Shared constants, types and the exponential table builder for the
// Gaussian particle splat core.
// ----------------------------------------------------------------------------
package gps_pkg;

    // image and table geometry
    localparam int IMG_W     = 256;
    localparam int IMG_H     = 256;
    localparam int IMG_DEPTH = IMG_W * IMG_H;
    localparam int EXP_DEPTH = 1024;

    localparam int COL_W  = $clog2(IMG_W);
    localparam int ROW_W  = $clog2(IMG_H);
    localparam int ADDR_W = $clog2(IMG_DEPTH);
    localparam int EXP_AW = $clog2(EXP_DEPTH);

    // field widths
    localparam int REQ_W   = 2;
    localparam int POS_W   = 20;
    localparam int INT_W   = 24;
    localparam int SIG_W   = 16;
    localparam int RC_W    = 8;
    localparam int RF_W    = 8;
    localparam int PW_W    = 16;
    localparam int PIX_W   = 32;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 24;

    // datapath widths
    localparam int R16_W   = RF_W + SIG_W;
    localparam int RSQ_W   = 2 * R16_W;
    localparam int SIG2_W  = 2 * SIG_W;
    localparam int WI_W    = INT_W;
    localparam int ENTRY_W = 17;
    localparam int ADD_W   = WI_W + ENTRY_W - 16;
    localparam int BND_W   = POS_W + 10;
    localparam int WIN_W   = BND_W - 16;
    localparam int DX_W    = POS_W + 2;
    localparam int SQ_W    = 2 * DX_W - 1;
    localparam int D2_W    = SQ_W + 1;
    localparam int TAB_SH  = 4;
    localparam int NUM_SH  = EXP_AW + TAB_SH;
    localparam int REM_W   = SIG2_W + EXP_AW + 1;
    localparam int DSR_W   = SIG2_W + EXP_AW;
    localparam int CNT_W   = $clog2(EXP_AW + 1);

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SPLAT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_RADIUS_FACTOR = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_FIXED_SIGMA   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_SIGMA_MODE    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_PEAK_WEIGHT   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MIN_INTENSITY = 3'd4;

    typedef struct packed {
        logic [RF_W-1:0]  radius_factor;
        logic [SIG_W-1:0] fixed_sigma;
        logic             sigma_mode;
        logic [PW_W-1:0]  peak_weight;
        logic [INT_W-1:0] min_intensity;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP1,
        ST_SETUP2,
        ST_SETUP3,
        ST_SQ,
        ST_CMP,
        ST_DIV,
        ST_ROM,
        ST_MUL,
        ST_ACC,
        ST_RD_ISSUE,
        ST_RD_DATA
    } t_state;

    typedef struct packed {
        logic load;
        logic setup1;
        logic setup2;
        logic win_load;
        logic sq;
        logic div_init;
        logic div_step;
        logic rom_rd;
        logic mul;
        logic acc_wr;
        logic next_px;
        logic clr_wr;
        logic rd_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic win_empty;
        logic in_rad;
        logic in_tab;
        logic div_last;
        logic last_px;
        logic clr_last;
    } t_sts;

    typedef logic [ENTRY_W-1:0] t_exp_rom [EXP_DEPTH];

    // exp(-x) over x in [0,16), Q1.16, from a series for exp(-x/64) raised
    // to the 64th power by six squarings
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom   rom;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u4;
        logic [63:0] u5;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            u   = (64'(i) << 31) / 64'(4 * EXP_DEPTH);
            u2  = (u * u) >> 31;
            u3  = (u2 * u) >> 31;
            u4  = (u3 * u) >> 31;
            u5  = (u4 * u) >> 31;
            pos = (64'd1 << 31) + u2 / 64'd2 + u4 / 64'd24;
            neg = u + u3 / 64'd6 + u5 / 64'd120;
            e   = pos - neg;
            for (int k = 0; k < 6; k++) begin
                e = (e * e) >> 31;
            end
            rom[i] = ENTRY_W'((e + (64'd1 << 14)) >> 15);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/core/gps_ctrl.sv =====
// ----------------------------------------------------------------------------
// gps_ctrl
// Request sequencer: clear sweep, splat window walk and pixel read.
// ----------------------------------------------------------------------------
module gps_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [gps_pkg::REQ_W-1:0] i_req_type,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output gps_pkg::t_cmd             o_cmd,
    input  gps_pkg::t_sts             i_sts
);
    import gps_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_type)
                        REQ_CLEAR: n_state = ST_CLEAR;
                        REQ_SPLAT: n_state = ST_SETUP1;
                        REQ_READ:  n_state = ST_RD_ISSUE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP1: begin
                if (i_sts.skip) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.setup1 = 1'b1;
                    n_state      = ST_SETUP2;
                end
            end
            ST_SETUP2: begin
                o_cmd.setup2 = 1'b1;
                n_state      = ST_SETUP3;
            end
            ST_SETUP3: begin
                if (i_sts.win_empty) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.win_load = 1'b1;
                    n_state        = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                if (i_sts.in_rad && i_sts.in_tab) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    o_cmd.next_px = 1'b1;
                    n_state       = i_sts.last_px ? ST_IDLE : ST_SQ;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_ROM;
                end
            end
            ST_ROM: begin
                o_cmd.rom_rd = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_wr  = 1'b1;
                o_cmd.next_px = 1'b1;
                n_state       = i_sts.last_px ? ST_IDLE : ST_SQ;
            end
            ST_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                // hold the read data until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && i_sts.clr_last) |=> (r_state == ST_IDLE))
        else $error("clear sweep did not return to idle");

    a_no_div_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && !(i_sts.in_rad && i_sts.in_tab)) |=> (r_state != ST_DIV))
        else $error("divider started for a pixel outside the blob");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

// ===== rtl/core/gps_dpath.sv =====
// ----------------------------------------------------------------------------
// gps_dpath
// Splat arithmetic, serial table-index divider, exponential table and the
// image accumulator memory.
// ----------------------------------------------------------------------------
module gps_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gps_pkg::t_cfg                     i_cfg,
    input  logic signed [gps_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [gps_pkg::POS_W-1:0]  i_pos_y,
    input  logic [gps_pkg::INT_W-1:0]         i_intensity,
    input  logic [gps_pkg::SIG_W-1:0]         i_particle_sigma,
    input  logic [gps_pkg::RC_W-1:0]          i_read_col,
    input  logic [gps_pkg::RC_W-1:0]          i_read_row,
    input  gps_pkg::t_cmd                     i_cmd,
    output gps_pkg::t_sts                     o_sts,
    output logic [gps_pkg::PIX_W-1:0]         o_pixel_value
);
    import gps_pkg::*;

    localparam t_exp_rom EXP_ROM = build_exp_rom();

    logic [PIX_W-1:0] mem [IMG_DEPTH];

    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic [INT_W-1:0]        r_inten;
    logic [SIG_W-1:0]        r_sigma;
    logic [RC_W-1:0]         r_rd_col;
    logic [RC_W-1:0]         r_rd_row;
    logic [R16_W-1:0]        r_r16;
    logic [SIG2_W-1:0]       r_sig2;
    logic [RSQ_W-1:0]        r_rsq;
    logic [WI_W-1:0]         r_wi;
    logic signed [WIN_W-1:0] r_lo_x;
    logic signed [WIN_W-1:0] r_hi_x;
    logic signed [WIN_W-1:0] r_lo_y;
    logic signed [WIN_W-1:0] r_hi_y;
    logic [COL_W-1:0]        r_wlo_x;
    logic [COL_W-1:0]        r_whi_x;
    logic [ROW_W-1:0]        r_whi_y;
    logic [COL_W-1:0]        r_cx;
    logic [ROW_W-1:0]        r_cy;
    logic [SQ_W-1:0]         r_dx2;
    logic [SQ_W-1:0]         r_dy2;
    logic [REM_W-1:0]        r_rem;
    logic [DSR_W-1:0]        r_dsr;
    logic [EXP_AW-1:0]       r_q;
    logic [CNT_W-1:0]        r_cnt;
    logic [ENTRY_W-1:0]      r_entry;
    logic [ADD_W-1:0]        r_add;
    logic [PIX_W-1:0]        r_mem_q;
    logic [PIX_W-1:0]        r_pixel;
    logic [ADDR_W-1:0]       r_clr_addr;

    logic [SIG_W-1:0]          sig_sel;
    logic signed [BND_W-1:0]   px_s;
    logic signed [BND_W-1:0]   py_s;
    logic signed [BND_W-1:0]   r_s;
    logic signed [BND_W-1:0]   lo_xa;
    logic signed [BND_W-1:0]   hi_xa;
    logic signed [BND_W-1:0]   lo_ya;
    logic signed [BND_W-1:0]   hi_ya;
    logic signed [WIN_W-1:0]   lo_xc;
    logic signed [WIN_W-1:0]   hi_xc;
    logic signed [WIN_W-1:0]   lo_yc;
    logic signed [WIN_W-1:0]   hi_yc;
    logic [INT_W+PW_W-1:0]     wi_prod;
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    dy;
    logic signed [2*DX_W-1:0]  dx_sq;
    logic signed [2*DX_W-1:0]  dy_sq;
    logic [D2_W-1:0]           d2;
    logic [WI_W+ENTRY_W-1:0]   add_prod;
    logic [PIX_W:0]            acc_sum;
    logic                      rd_in_img;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         px_addr;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_wa;
    logic [PIX_W-1:0]          mem_wd;
    logic                      div_ge;

    // latch the request
    always_comb begin
        sig_sel = i_cfg.sigma_mode ? i_particle_sigma : i_cfg.fixed_sigma;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
            r_inten  <= i_intensity;
            r_sigma  <= (sig_sel == '0) ? SIG_W'(1) : sig_sel;
            r_rd_col <= i_read_col;
            r_rd_row <= i_read_row;
        end
    end

    // window bounds: floor and ceiling of (pos*256 -/+ r16) / 65536
    always_comb begin
        px_s  = BND_W'(r_px) <<< 8;
        py_s  = BND_W'(r_py) <<< 8;
        r_s   = $signed(BND_W'(r_r16));
        lo_xa = (px_s - r_s) >>> 16;
        hi_xa = (px_s + r_s + BND_W'(16'hFFFF)) >>> 16;
        lo_ya = (py_s - r_s) >>> 16;
        hi_ya = (py_s + r_s + BND_W'(16'hFFFF)) >>> 16;
        wi_prod = r_inten * i_cfg.peak_weight;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup1) begin
            r_r16  <= r_sigma * i_cfg.radius_factor;
            r_sig2 <= r_sigma * r_sigma;
        end
        if (i_cmd.setup2) begin
            r_rsq  <= r_r16 * r_r16;
            r_wi   <= wi_prod[INT_W+PW_W-1:16];
            r_lo_x <= lo_xa[WIN_W-1:0];
            r_hi_x <= hi_xa[WIN_W-1:0];
            r_lo_y <= lo_ya[WIN_W-1:0];
            r_hi_y <= hi_ya[WIN_W-1:0];
        end
    end

    // clip to the image
    always_comb begin
        lo_xc = (r_lo_x < 0) ? '0 : r_lo_x;
        lo_yc = (r_lo_y < 0) ? '0 : r_lo_y;
        hi_xc = (r_hi_x > WIN_W'(IMG_W - 1)) ? WIN_W'(IMG_W - 1) : r_hi_x;
        hi_yc = (r_hi_y > WIN_W'(IMG_H - 1)) ? WIN_W'(IMG_H - 1) : r_hi_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_load) begin
            r_wlo_x <= lo_xc[COL_W-1:0];
            r_whi_x <= hi_xc[COL_W-1:0];
            r_whi_y <= hi_yc[ROW_W-1:0];
            r_cx    <= lo_xc[COL_W-1:0];
            r_cy    <= lo_yc[ROW_W-1:0];
        end else if (i_cmd.next_px) begin
            if (r_cx == r_whi_x) begin
                r_cx <= r_wlo_x;
                r_cy <= r_cy + 1'b1;
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
    end

    // squared distance in Q.16
    always_comb begin
        dx    = DX_W'($signed({1'b0, r_cx, 8'b0})) - DX_W'(r_px);
        dy    = DX_W'($signed({1'b0, r_cy, 8'b0})) - DX_W'(r_py);
        dx_sq = dx * dx;
        dy_sq = dy * dy;
        d2    = D2_W'(r_dx2) + D2_W'(r_dy2);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_dx2 <= dx_sq[SQ_W-1:0];
            r_dy2 <= dy_sq[SQ_W-1:0];
        end
    end

    // restoring divider for the table index, one quotient bit a cycle
    assign div_ge = (r_rem >= REM_W'(r_dsr));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= REM_W'({d2, NUM_SH'(0)});
            r_dsr <= DSR_W'(r_sig2) << (EXP_AW - 1);
            r_q   <= '0;
            r_cnt <= CNT_W'(EXP_AW - 1);
        end else if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - REM_W'(r_dsr);
            end
            r_q   <= {r_q[EXP_AW-2:0], div_ge};
            r_dsr <= r_dsr >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rom_rd) begin
            r_entry <= EXP_ROM[r_q];
        end
        if (i_cmd.mul) begin
            r_add <= add_prod[WI_W+ENTRY_W-1:16];
        end
    end

    assign add_prod = r_wi * r_entry;

    // image memory
    always_comb begin
        rd_in_img = (9'(r_rd_col) < 9'(IMG_W)) && (9'(r_rd_row) < 9'(IMG_H));
        rd_addr   = ADDR_W'(r_rd_row) * ADDR_W'(IMG_W) + ADDR_W'(r_rd_col);
        px_addr   = ADDR_W'(r_cy) * ADDR_W'(IMG_W) + ADDR_W'(r_cx);
        acc_sum   = {1'b0, r_mem_q} + (PIX_W + 1)'(r_add);
        mem_we    = i_cmd.clr_wr || i_cmd.acc_wr;
        mem_wa    = i_cmd.clr_wr ? r_clr_addr : px_addr;
        mem_wd    = i_cmd.clr_wr ? '0 : (acc_sum[PIX_W] ? '1 : acc_sum[PIX_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_mem_q <= mem[rd_addr];
        end else if (i_cmd.rom_rd) begin
            r_mem_q <= mem[px_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.load) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pixel <= rd_in_img ? r_mem_q : '0;
        end
    end

    assign o_pixel_value = r_pixel;

    always_comb begin
        o_sts.skip      = (r_inten <= i_cfg.min_intensity);
        o_sts.win_empty = (lo_xc > hi_xc) || (lo_yc > hi_yc);
        o_sts.in_rad    = ({d2, 16'b0} <= (D2_W + 16)'(r_rsq));
        o_sts.in_tab    = ({d2, TAB_SH'(0)} < (D2_W + TAB_SH)'(r_sig2));
        o_sts.div_last  = (r_cnt == '0);
        o_sts.last_px   = (r_cx == r_whi_x) && (r_cy == r_whi_y);
        o_sts.clr_last  = (r_clr_addr == ADDR_W'(IMG_DEPTH - 1));
    end

endmodule

// ===== rtl/core/gaussian_particle_splat_core.sv =====
// ----------------------------------------------------------------------------
// gaussian_particle_splat_core
// Splats 2D particles as Gaussian blobs into a 256x256 Q16.16 accumulator.
// ----------------------------------------------------------------------------
// Request channel: i_in_valid / o_in_stall, with req_type clear, splat or
// read plus the particle and pixel fields. One request is worked at a time;
// o_in_stall is high from acceptance until the request is finished.
// Result channel: o_out_valid / i_out_stall carries pixel_value, one result
// per read request only. The result sits in an output register, so a new
// request is taken while it still waits; a read that finds the register
// full waits in its last step until the receiver takes the old result.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index and data.
// Steps per request: read issues the memory read, then loads the result
// register; clear writes one pixel per cycle; splat runs the setup states
// ST_SETUP1 to ST_SETUP3 plus, per window pixel, a square and a compare step
// when outside the blob, and inside also the one-bit-per-cycle table-index
// divider (10 steps), the table read, the multiply and the read-modify-write
// of the image memory. Reset: a clearing pass over all 65536 pixels zeroes
// the image; requests are held off meanwhile, configuration writes are taken.
// ----------------------------------------------------------------------------
module gaussian_particle_splat_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [gps_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [gps_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [gps_pkg::POS_W-1:0]   i_pos_y,
    input  logic [gps_pkg::INT_W-1:0]          i_intensity,
    input  logic [gps_pkg::SIG_W-1:0]          i_particle_sigma,
    input  logic [gps_pkg::RC_W-1:0]           i_read_col,
    input  logic [gps_pkg::RC_W-1:0]           i_read_row,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [gps_pkg::PIX_W-1:0]          o_pixel_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gps_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [gps_pkg::CFG_DW-1:0]         i_cfg_data
);
    import gps_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius_factor <= RF_W'(64);
            r_cfg.fixed_sigma   <= SIG_W'(4096);
            r_cfg.sigma_mode    <= 1'b0;
            r_cfg.peak_weight   <= PW_W'(26145);
            r_cfg.min_intensity <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RADIUS_FACTOR: r_cfg.radius_factor <= i_cfg_data[RF_W-1:0];
                CFG_FIXED_SIGMA:   r_cfg.fixed_sigma   <= i_cfg_data[SIG_W-1:0];
                CFG_SIGMA_MODE:    r_cfg.sigma_mode    <= i_cfg_data[0];
                CFG_PEAK_WEIGHT:   r_cfg.peak_weight   <= i_cfg_data[PW_W-1:0];
                CFG_MIN_INTENSITY: r_cfg.min_intensity <= i_cfg_data[INT_W-1:0];
                default: ;
            endcase
        end
    end

    gps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gps_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_intensity      (i_intensity),
        .i_particle_sigma (i_particle_sigma),
        .i_read_col       (i_read_col),
        .i_read_row       (i_read_row),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_pixel_value    (o_pixel_value)
    );

endmodule
